/* hdl/yuvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// yuvrgb_pkg
// Shared types, format codes and coefficients for the YUV to RGB packer.
// ----------------------------------------------------------------------------
package yuvrgb_pkg;

  // output format codes
  localparam logic [2:0] PIX_R5G6B5   = 3'd0;
  localparam logic [2:0] PIX_A1R5G5B5 = 3'd1;
  localparam logic [2:0] PIX_R8G8B8   = 3'd2;
  localparam logic [2:0] PIX_B8G8R8   = 3'd3;
  localparam logic [2:0] PIX_A8R8G8B8 = 3'd4;
  localparam logic [2:0] PIX_A8B8G8R8 = 3'd5;
  localparam logic [2:0] PIX_R8G8B8A8 = 3'd6;
  localparam logic [2:0] PIX_B8G8R8A8 = 3'd7;

  localparam logic [2:0] FMT_RESET = PIX_B8G8R8;

  // byte counts of the packed pixel
  localparam logic [2:0] BYTES_16 = 3'd2;
  localparam logic [2:0] BYTES_24 = 3'd3;
  localparam logic [2:0] BYTES_32 = 3'd4;

  // coefficients scaled by 128
  localparam int CoefY  = 149;
  localparam int CoefRV = 148;
  localparam int CoefGU = 49;
  localparam int CoefGV = 104;
  localparam int CoefBU = 255;

  localparam int LumaOffset  = 16;
  localparam int FracBits    = 7;
  localparam int SumWidth    = 19;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

/* hdl/yuvrgb_if.sv */
// ----------------------------------------------------------------------------
// yuvrgb_if
// Valid/ready channels: YUV pixel in, packed pixel out, format register write.
// ----------------------------------------------------------------------------
interface yuvrgb_yuv_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] chroma_blue;
  logic [7:0] chroma_red;

  modport source (output valid, output luma, output chroma_blue, output chroma_red,
                  input ready);
  modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                  output ready);
endinterface

interface yuvrgb_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  logic [2:0]  pixel_bytes;

  modport source (output valid, output pixel_word, output pixel_bytes, input ready);
  modport sink   (input valid, input pixel_word, input pixel_bytes, output ready);
endinterface

interface yuvrgb_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] output_format;

  modport source (output valid, output output_format, input ready);
  modport sink   (input valid, input output_format, output ready);
endinterface

/* hdl/yuvrgb_convert.sv */
// ----------------------------------------------------------------------------
// yuvrgb_convert
// Fixed-point YUV to RGB matrix, floor shift by 7 and clamp to 0..255.
// ----------------------------------------------------------------------------
module yuvrgb_convert (
  input  logic [7:0]         luma_i,
  input  logic [7:0]         chroma_blue_i,
  input  logic [7:0]         chroma_red_i,
  output yuvrgb_pkg::rgb_t   rgb_o
);
  import yuvrgb_pkg::*;

  localparam int ShWidth = SumWidth - FracBits;

  logic signed [8:0]          y_s;
  logic signed [7:0]          u_s;
  logic signed [7:0]          v_s;
  logic signed [SumWidth-1:0] y_term;
  logic signed [SumWidth-1:0] r_sum;
  logic signed [SumWidth-1:0] g_sum;
  logic signed [SumWidth-1:0] b_sum;

  function automatic logic [7:0] clamp8(input logic signed [SumWidth-1:0] sum);
    logic signed [ShWidth-1:0] sh;
    sh = ShWidth'(sum >>> FracBits);
    if (sh < 0) begin
      clamp8 = 8'd0;
    end else if (sh > ShWidth'(255)) begin
      clamp8 = 8'hff;
    end else begin
      clamp8 = sh[7:0];
    end
  endfunction

  // offset 128 chroma: flip the top bit to get the signed difference
  assign y_s = $signed({1'b0, luma_i}) - 9'(LumaOffset);
  assign u_s = $signed({~chroma_blue_i[7], chroma_blue_i[6:0]});
  assign v_s = $signed({~chroma_red_i[7], chroma_red_i[6:0]});

  assign y_term = SumWidth'(y_s) * SumWidth'(CoefY);
  assign r_sum  = y_term + SumWidth'(v_s) * SumWidth'(CoefRV);
  assign g_sum  = y_term - SumWidth'(u_s) * SumWidth'(CoefGU)
                         - SumWidth'(v_s) * SumWidth'(CoefGV);
  assign b_sum  = y_term + SumWidth'(u_s) * SumWidth'(CoefBU);

  assign rgb_o.red   = clamp8(r_sum);
  assign rgb_o.green = clamp8(g_sum);
  assign rgb_o.blue  = clamp8(b_sum);

endmodule

/* hdl/yuvrgb_pack.sv */
// ----------------------------------------------------------------------------
// yuvrgb_pack
// Channel swap and packing of one RGB pixel into the selected format.
// ----------------------------------------------------------------------------
module yuvrgb_pack (
  input  yuvrgb_pkg::rgb_t rgb_i,
  input  logic [2:0]       fmt_i,
  output logic [31:0]      pixel_word_o,
  output logic [2:0]       pixel_bytes_o
);
  import yuvrgb_pkg::*;

  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;
  logic       swap;

  // BGR-ordered formats trade red and blue
  assign swap = (fmt_i == PIX_B8G8R8) || (fmt_i == PIX_A8B8G8R8) ||
                (fmt_i == PIX_B8G8R8A8);
  assign r = swap ? rgb_i.blue : rgb_i.red;
  assign g = rgb_i.green;
  assign b = swap ? rgb_i.red : rgb_i.blue;

  always_comb begin
    case (fmt_i)
      PIX_R5G6B5: begin
        pixel_word_o  = {16'd0, r[7:3], g[7:2], b[7:3]};
        pixel_bytes_o = BYTES_16;
      end
      PIX_A1R5G5B5: begin
        pixel_word_o  = {16'd0, 1'b1, r[7:3], g[7:3], b[7:3]};
        pixel_bytes_o = BYTES_16;
      end
      PIX_R8G8B8, PIX_B8G8R8: begin
        pixel_word_o  = {8'd0, b, g, r};
        pixel_bytes_o = BYTES_24;
      end
      PIX_A8R8G8B8, PIX_A8B8G8R8: begin
        pixel_word_o  = {ALPHA_OPAQUE, r, g, b};
        pixel_bytes_o = BYTES_32;
      end
      default: begin
        pixel_word_o  = {r, g, b, ALPHA_OPAQUE};
        pixel_bytes_o = BYTES_32;
      end
    endcase
  end

endmodule

/* hdl/yuv_to_rgb_pixel_pack.sv */
// ----------------------------------------------------------------------------
// yuv_to_rgb_pixel_pack
// Converts YUV pixels to clamped RGB and packs them into one of eight formats.
// ----------------------------------------------------------------------------
//  channel  dir  payload                              handshake
//  yuv_i    in   luma, chroma_blue, chroma_red        valid/ready
//  pix_o    out  pixel_word[31:0], pixel_bytes[2:0]   valid/ready
//  cfg_i    in   output_format[2:0]                   valid/ready, always ready
//
//  One item per cycle sustained while pix_o is ready; an accepted item passes
//  through the input register and then the result register before pix_o.valid.
//  Stage one is the input register, stage two the result register; the matrix,
//  clamp and packing sit between them.
//  Reset clears both stage valids and sets the format to bgr888.
//  A stall on pix_o holds the result register; the input register still takes
//  an item while it is empty or the result register can load.
// ----------------------------------------------------------------------------
module yuv_to_rgb_pixel_pack (
  input  logic          clk_i,
  input  logic          rst_ni,
  yuvrgb_yuv_if.sink    yuv_i,
  yuvrgb_pix_if.source  pix_o,
  yuvrgb_cfg_if.sink    cfg_i
);
  import yuvrgb_pkg::*;

  logic [2:0]  fmt_q;
  logic        s1_valid_q;
  logic [7:0]  luma_q;
  logic [7:0]  cb_q;
  logic [7:0]  cr_q;
  logic        s2_valid_q;
  logic [31:0] word_q;
  logic [2:0]  bytes_q;

  logic        s2_load;
  logic        s1_load;
  rgb_t        rgb;
  logic [31:0] word_d;
  logic [2:0]  bytes_d;

  assign cfg_i.ready = 1'b1;

  assign s2_load     = !s2_valid_q || pix_o.ready;
  assign yuv_i.ready = !s1_valid_q || s2_load;
  assign s1_load     = yuv_i.valid && yuv_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q      <= FMT_RESET;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        fmt_q <= cfg_i.output_format;
      end
      if (yuv_i.ready) begin
        s1_valid_q <= yuv_i.valid;
      end
      if (s2_load) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      luma_q <= yuv_i.luma;
      cb_q   <= yuv_i.chroma_blue;
      cr_q   <= yuv_i.chroma_red;
    end
    if (s2_load && s1_valid_q) begin
      word_q  <= word_d;
      bytes_q <= bytes_d;
    end
  end

  yuvrgb_convert u_convert (
    .luma_i        (luma_q),
    .chroma_blue_i (cb_q),
    .chroma_red_i  (cr_q),
    .rgb_o         (rgb)
  );

  yuvrgb_pack u_pack (
    .rgb_i         (rgb),
    .fmt_i         (fmt_q),
    .pixel_word_o  (word_d),
    .pixel_bytes_o (bytes_d)
  );

  assign pix_o.valid       = s2_valid_q;
  assign pix_o.pixel_word  = word_q;
  assign pix_o.pixel_bytes = bytes_q;

  // input back-pressure only when both stages are full and the sink stalls
  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !yuv_i.ready |-> (s1_valid_q && s2_valid_q && !pix_o.ready))
    else $error("input stalled while a stage was free");

  a_16bit_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.pixel_bytes == BYTES_16) |-> (pix_o.pixel_word[31:16] == 16'd0))
    else $error("16-bit pixel has upper half set");

  a_24bit_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.pixel_bytes == BYTES_24) |-> (pix_o.pixel_word[31:24] == 8'd0))
    else $error("24-bit pixel has top byte set");

  a_32bit_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pix_o.valid && pix_o.pixel_bytes == BYTES_32) |->
      (pix_o.pixel_word[31:24] == ALPHA_OPAQUE || pix_o.pixel_word[7:0] == ALPHA_OPAQUE))
    else $error("32-bit pixel without opaque alpha");

  a_bytes_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_o.valid |-> (pix_o.pixel_bytes == BYTES_16 || pix_o.pixel_bytes == BYTES_24 ||
                     pix_o.pixel_bytes == BYTES_32))
    else $error("illegal pixel byte count");

endmodule
